>>> design/mfcr_pkg.sv
// ----------------------------------------------------------------------------
// mfcr_pkg
// Shared types, register indexes, status codes and the CRC-16 byte update
// for the frame check and routing block.
// ----------------------------------------------------------------------------
package mfcr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned DEST_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] LEN_MAX  = 8'hFF;
    localparam logic [BYTE_W-1:0] LEN_MIN  = 8'd3;

    // Reset values of the configuration registers.
    localparam logic              RST_WILDCARD_EN  = 1'b1;
    localparam logic [BYTE_W-1:0] RST_WILDCARD_VAL = 8'hAA;
    localparam logic [DEST_W-1:0] RST_BCAST_MASK   = 4'h3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WILDCARD_EN  = 2'd0,
        CFG_WILDCARD_VAL = 2'd1,
        CFG_BCAST_MASK   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_SHORT    = 2'd2,
        ST_BAD_ADDR = 2'd3
    } t_status;

    typedef struct packed {
        logic              wildcard_en;
        logic [BYTE_W-1:0] wildcard_val;
        logic [DEST_W-1:0] bcast_mask;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic [DEST_W-1:0] dest_mask;
        logic              is_broadcast;
        logic [BYTE_W-1:0] frame_length;
    } t_result;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

>>> design/mfcr_frame.sv
// ----------------------------------------------------------------------------
// mfcr_frame
// Per-frame state (CRC, two-byte trailer delay line, address, length) and
// the end-of-frame check and routing decision for the byte being stepped.
// ----------------------------------------------------------------------------
module mfcr_frame #(
    parameter int unsigned NUM_CLIENTS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [mfcr_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eof,
    input  mfcr_pkg::t_cfg             i_cfg,
    output mfcr_pkg::t_result          o_result
);

    localparam int unsigned MAX_ADDR = (NUM_CLIENTS < mfcr_pkg::DEST_W) ?
                                       NUM_CLIENTS : mfcr_pkg::DEST_W;
    localparam logic [mfcr_pkg::DEST_W-1:0] CLIENT_MASK =
        mfcr_pkg::DEST_W'((1 << MAX_ADDR) - 1);

    logic [mfcr_pkg::CRC_W-1:0]  r_crc,   n_crc;
    logic [mfcr_pkg::BYTE_W-1:0] r_d0,    n_d0;
    logic [mfcr_pkg::BYTE_W-1:0] r_d1,    n_d1;
    logic [mfcr_pkg::BYTE_W-1:0] r_addr,  n_addr;
    logic [mfcr_pkg::BYTE_W-1:0] r_count, n_count;

    logic [mfcr_pkg::CRC_W-1:0]  crc_upd;
    logic [mfcr_pkg::BYTE_W-1:0] addr_upd;
    logic [mfcr_pkg::BYTE_W-1:0] len_upd;
    logic [mfcr_pkg::BYTE_W-1:0] addr_m1;
    logic                        lo_ok, hi_ok;

    always_comb begin
        // The byte two places back enters the CRC only once it is known
        // not to belong to the trailer.
        crc_upd  = (r_count[7:1] != '0) ? mfcr_pkg::crc16_byte(r_crc, r_d1) : r_crc;
        addr_upd = (r_count == '0) ? i_byte : r_addr;
        len_upd  = (r_count == mfcr_pkg::LEN_MAX) ? r_count : r_count + 8'd1;
        addr_m1  = addr_upd - 8'd1;

        lo_ok = (r_d0 == crc_upd[7:0]) ||
                (i_cfg.wildcard_en && (r_d0 == i_cfg.wildcard_val));
        hi_ok = (i_byte == crc_upd[15:8]) ||
                (i_cfg.wildcard_en && (i_byte == i_cfg.wildcard_val));

        o_result.is_broadcast = (addr_upd == '0);
        o_result.frame_length = len_upd;
        o_result.dest_mask    = '0;
        if (len_upd < mfcr_pkg::LEN_MIN) begin
            o_result.status = mfcr_pkg::ST_SHORT;
        end else if (!(lo_ok && hi_ok)) begin
            o_result.status = mfcr_pkg::ST_CRC_ERR;
        end else if (addr_upd == '0) begin
            o_result.status    = mfcr_pkg::ST_OK;
            o_result.dest_mask = i_cfg.bcast_mask & CLIENT_MASK;
        end else if (addr_upd <= mfcr_pkg::BYTE_W'(MAX_ADDR)) begin
            o_result.status    = mfcr_pkg::ST_OK;
            o_result.dest_mask = mfcr_pkg::DEST_W'(1) << addr_m1[1:0];
        end else begin
            o_result.status = mfcr_pkg::ST_BAD_ADDR;
        end

        n_crc   = r_crc;
        n_d0    = r_d0;
        n_d1    = r_d1;
        n_addr  = r_addr;
        n_count = r_count;
        if (i_step) begin
            if (i_eof) begin
                n_crc   = mfcr_pkg::CRC_INIT;
                n_d0    = '0;
                n_d1    = '0;
                n_addr  = '0;
                n_count = '0;
            end else begin
                n_crc   = crc_upd;
                n_d0    = i_byte;
                n_d1    = r_d0;
                n_addr  = addr_upd;
                n_count = len_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mfcr_pkg::CRC_INIT;
            r_d0    <= '0;
            r_d1    <= '0;
            r_addr  <= '0;
            r_count <= '0;
        end else begin
            r_crc   <= n_crc;
            r_d0    <= n_d0;
            r_d1    <= n_d1;
            r_addr  <= n_addr;
            r_count <= n_count;
        end
    end

endmodule

>>> design/modbus_frame_check_router_core.sv
// ----------------------------------------------------------------------------
// modbus_frame_check_router_core
// Checks the CRC-16 trailer of Modbus RTU frames and routes valid frames.
// ----------------------------------------------------------------------------
// Frame bytes enter on the input channel (i_in_valid / o_in_ready) with a
// mark on the final byte. One result leaves on the output channel
// (o_out_valid / i_out_ready) for each frame, on its final byte; other bytes
// give no result. A byte is registered on transfer into the input register;
// when it is stepped, the frame logic updates the CRC and, on the final byte,
// writes the check and routing result into the output register. One byte is
// taken every cycle; the only limit is the single output register. When the
// receiver stalls and a result waits, ordinary bytes still flow, and a final
// byte stays in the input register, holding o_in_ready low, until the
// waiting result is taken.
// The configuration port writes wildcard enable, wildcard value and broadcast
// mask by index; indexes past the last register are ignored. Write it only
// while no frame is in flight. Reset clears the channels, the frame state and
// restores the configuration defaults.
// ----------------------------------------------------------------------------
module modbus_frame_check_router_core #(
    parameter int unsigned NUM_CLIENTS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mfcr_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_end_of_frame,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [mfcr_pkg::DEST_W-1:0]   o_dest_mask,
    output logic                          o_is_broadcast,
    output logic [mfcr_pkg::BYTE_W-1:0]   o_frame_length,
    input  logic                          i_cfg_we,
    input  logic [mfcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mfcr_pkg::BYTE_W-1:0]   i_cfg_data
);

    mfcr_pkg::t_cfg    r_cfg;
    mfcr_pkg::t_result frame_res;
    mfcr_pkg::t_result r_out;

    logic                        r_in_valid;
    logic [mfcr_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_eof;
    logic                        r_out_valid;
    logic                        step;
    logic                        out_free;

    // A final byte needs a free output register; other bytes never wait.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!r_in_eof || out_free);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wildcard_en  <= mfcr_pkg::RST_WILDCARD_EN;
            r_cfg.wildcard_val <= mfcr_pkg::RST_WILDCARD_VAL;
            r_cfg.bcast_mask   <= mfcr_pkg::RST_BCAST_MASK;
        end else if (i_cfg_we) begin
            case (mfcr_pkg::t_cfg_idx'(i_cfg_index))
                mfcr_pkg::CFG_WILDCARD_EN:  r_cfg.wildcard_en  <= i_cfg_data[0];
                mfcr_pkg::CFG_WILDCARD_VAL: r_cfg.wildcard_val <= i_cfg_data;
                mfcr_pkg::CFG_BCAST_MASK:   r_cfg.bcast_mask   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_frame;
        end
    end

    mfcr_frame #(
        .NUM_CLIENTS(NUM_CLIENTS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .i_cfg   (r_cfg),
        .o_result(frame_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_eof) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_eof) begin
            r_out <= frame_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_dest_mask    = r_out.dest_mask;
    assign o_is_broadcast = r_out.is_broadcast;
    assign o_frame_length = r_out.frame_length;

endmodule

>>> design/mfcr_checker.sv
// ----------------------------------------------------------------------------
// mfcr_checker
// Port-level checks on the results of the frame check and routing block.
// ----------------------------------------------------------------------------
module mfcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  o_status,
    input logic [mfcr_pkg::DEST_W-1:0] o_dest_mask,
    input logic                        o_is_broadcast,
    input logic [mfcr_pkg::BYTE_W-1:0] o_frame_length
);

    // A result waiting on a stalled receiver must not vanish.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_reject_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != mfcr_pkg::ST_OK) |-> o_dest_mask == '0)
        else $error("rejected frame has destinations");

    a_unicast_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == mfcr_pkg::ST_OK) && !o_is_broadcast
        |-> $onehot(o_dest_mask))
        else $error("unicast frame not routed to exactly one client");

    a_short_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == mfcr_pkg::ST_SHORT) ==
                         (o_frame_length < mfcr_pkg::LEN_MIN)))
        else $error("short status disagrees with frame length");

endmodule

bind modbus_frame_check_router_core mfcr_checker u_mfcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_dest_mask   (o_dest_mask),
    .o_is_broadcast(o_is_broadcast),
    .o_frame_length(o_frame_length)
);
